@@ hdl/fwts_pkg.sv @@
// ----------------------------------------------------------------------------
// fwts_pkg
// Types, request and phase codes and small helpers shared by the
// fixed-weight ternary sampler and its checker.
// ----------------------------------------------------------------------------
package fwts_pkg;

    localparam int CAND_W    = 10;
    localparam int COEF_W    = 2;
    localparam int CNT_W     = 10;
    localparam int LEN_W     = 11;
    localparam int WT_W      = 9;
    localparam int PH_W      = 2;
    localparam int REQ_W     = 2;
    localparam int WORD_W    = 64;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 11;

    typedef logic [COEF_W-1:0] t_coef;

    localparam t_coef COEF_ZERO  = 2'b00;
    localparam t_coef COEF_PLUS  = 2'b01;
    localparam t_coef COEF_MINUS = 2'b11;

    localparam logic [REQ_W-1:0] REQ_START = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WORD  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    localparam logic [PH_W-1:0] PH_PLUS  = 2'd0;
    localparam logic [PH_W-1:0] PH_MINUS = 2'd1;
    localparam logic [PH_W-1:0] PH_DONE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_POLY_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MINUS_WEIGHT = 1'b1;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [WORD_W-1:0] random_word;
        logic [CAND_W-1:0] read_index;
    } t_req_item;

    typedef struct packed {
        logic signed [COEF_W-1:0] coefficient;
        logic [PH_W-1:0]          phase;
        logic [CNT_W-1:0]         placed_in_phase;
    } t_res_item;

    typedef struct packed {
        logic [LEN_W-1:0] poly_length;
        logic [WT_W-1:0]  minus_weight;
    } t_cfg;

    // one write port and one read port of the coefficient memory
    typedef struct packed {
        logic              wr_en;
        logic [CAND_W-1:0] wr_addr;
        t_coef             wr_data;
        logic [CAND_W-1:0] rd_addr;
    } t_mem_cmd;

    function automatic logic [PH_W-1:0] next_phase(input logic [PH_W-1:0] ph,
                                                   input logic [WT_W-1:0] mw);
        logic [PH_W-1:0] nxt;
        if (ph == PH_PLUS) begin
            nxt = (mw == '0) ? PH_DONE : PH_MINUS;
        end else begin
            nxt = PH_DONE;
        end
        return nxt;
    endfunction

    function automatic logic [CNT_W-1:0] target_of(input logic [PH_W-1:0] ph,
                                                   input logic [WT_W-1:0] mw);
        logic [CNT_W-1:0] tgt;
        if (ph == PH_PLUS) begin
            tgt = CNT_W'(mw) + CNT_W'(1);
        end else begin
            tgt = CNT_W'(mw);
        end
        return tgt;
    endfunction

endpackage

@@ hdl/fwts_mem.sv @@
// ----------------------------------------------------------------------------
// fwts_mem
// Coefficient store: one synchronous write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module fwts_mem #(
    parameter int DEPTH = 1024
) (
    input  logic              i_clk,
    input  fwts_pkg::t_mem_cmd i_cmd,
    output fwts_pkg::t_coef    o_rd_data
);
    import fwts_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_coef r_mem [DEPTH];
    t_coef r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr[AW-1:0]] <= i_cmd.wr_data;
        end
        r_rd_data <= r_mem[i_cmd.rd_addr[AW-1:0]];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/fwts_seq.sv @@
// ----------------------------------------------------------------------------
// fwts_seq
// Request sequencer: clearing sweep, read-modify-write of candidate slots
// against the coefficient memory, coefficient reads and the result beat.
// ----------------------------------------------------------------------------
module fwts_seq #(
    parameter int MAX_LENGTH     = 1024,
    parameter int SLOTS_PER_WORD = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  fwts_pkg::t_req_item  i_req,
    input  fwts_pkg::t_cfg       i_cfg,
    input  fwts_pkg::t_coef      i_rd_data,
    output logic                 o_busy,
    output fwts_pkg::t_mem_cmd   o_mem,
    output logic                 o_strobe,
    output fwts_pkg::t_res_item  o_res
);
    import fwts_pkg::*;

    localparam int AW = $clog2(MAX_LENGTH);
    localparam int SW = $clog2(SLOTS_PER_WORD + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LENGTH);

    typedef enum logic [1:0] {
        S_CLR,
        S_IDLE,
        S_WORD,
        S_READ
    } t_state;

    t_state            r_state;
    logic [AW-1:0]     r_clr_addr;
    logic              r_clr_reply;
    logic [PH_W-1:0]   r_phase;
    logic [CNT_W-1:0]  r_count;
    logic [WORD_W-1:0] r_word;
    logic [SW-1:0]     r_iss;
    logic              r_ev_vld;
    logic [CAND_W-1:0] r_ev_addr;
    logic              r_fwd_vld;
    logic [CAND_W-1:0] r_fwd_addr;
    logic              r_rd_oob;
    logic              r_strobe;
    t_res_item         r_res;

    logic [LEN_W-1:0]  len_eff;
    logic [CNT_W-1:0]  tgt;
    logic [CNT_W-1:0]  cnt_inc;
    logic              hit;
    logic              take;
    logic              reached;
    logic              issue;
    logic [PH_W-1:0]   ph_next;
    t_coef             place_val;

    always_comb begin
        len_eff   = (i_cfg.poly_length > LEN_MAX) ? LEN_MAX : i_cfg.poly_length;
        tgt       = target_of(r_phase, i_cfg.minus_weight);
        ph_next   = next_phase(r_phase, i_cfg.minus_weight);
        cnt_inc   = r_count + CNT_W'(1);
        place_val = (r_phase == PH_PLUS) ? COEF_PLUS : COEF_MINUS;
        // the read issued alongside the last write misses that write
        hit       = (i_rd_data != COEF_ZERO) || (r_fwd_vld && (r_fwd_addr == r_ev_addr));
        take      = (r_state == S_WORD) && r_ev_vld && ({1'b0, r_ev_addr} < len_eff) && !hit;
        reached   = (cnt_inc >= tgt);
        issue     = (r_iss != SW'(SLOTS_PER_WORD));
    end

    always_comb begin
        o_mem.wr_en   = 1'b0;
        o_mem.wr_addr = CAND_W'(r_clr_addr);
        o_mem.wr_data = COEF_ZERO;
        o_mem.rd_addr = r_word[CAND_W-1:0];
        case (r_state)
            S_CLR: begin
                o_mem.wr_en = 1'b1;
            end
            S_IDLE: begin
                o_mem.rd_addr = i_req.read_index;
            end
            S_WORD: begin
                if (take) begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = r_ev_addr;
                    o_mem.wr_data = place_val;
                end
            end
            default: begin
                o_mem.wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_strobe <= 1'b0;
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_phase     <= PH_PLUS;
            r_count     <= '0;
            r_iss       <= '0;
            r_ev_vld    <= 1'b0;
            r_fwd_vld   <= 1'b0;
        end else begin
            case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(MAX_LENGTH - 1)) begin
                        r_state <= S_IDLE;
                        if (r_clr_reply) begin
                            r_strobe              <= 1'b1;
                            r_res.coefficient     <= COEF_ZERO;
                            r_res.phase           <= r_phase;
                            r_res.placed_in_phase <= r_count;
                        end
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        case (i_req.req_type)
                            REQ_START: begin
                                r_phase     <= PH_PLUS;
                                r_count     <= '0;
                                r_clr_addr  <= '0;
                                r_clr_reply <= 1'b1;
                                r_state     <= S_CLR;
                            end
                            REQ_WORD: begin
                                r_word    <= i_req.random_word;
                                r_iss     <= '0;
                                r_ev_vld  <= 1'b0;
                                r_fwd_vld <= 1'b0;
                                if (r_phase == PH_DONE) begin
                                    r_strobe              <= 1'b1;
                                    r_res.coefficient     <= COEF_ZERO;
                                    r_res.phase           <= r_phase;
                                    r_res.placed_in_phase <= r_count;
                                end else if (r_count >= tgt) begin
                                    // count already met after a register change
                                    r_phase               <= ph_next;
                                    r_count               <= '0;
                                    r_strobe              <= 1'b1;
                                    r_res.coefficient     <= COEF_ZERO;
                                    r_res.phase           <= ph_next;
                                    r_res.placed_in_phase <= '0;
                                end else begin
                                    r_state <= S_WORD;
                                end
                            end
                            REQ_READ: begin
                                r_rd_oob <= ({1'b0, i_req.read_index} >= LEN_MAX);
                                r_state  <= S_READ;
                            end
                            default: begin
                                r_strobe              <= 1'b1;
                                r_res.coefficient     <= COEF_ZERO;
                                r_res.phase           <= r_phase;
                                r_res.placed_in_phase <= r_count;
                            end
                        endcase
                    end
                end
                S_WORD: begin
                    r_fwd_vld  <= take;
                    r_fwd_addr <= r_ev_addr;
                    if (issue) begin
                        r_word    <= r_word >> CAND_W;
                        r_iss     <= r_iss + SW'(1);
                        r_ev_vld  <= 1'b1;
                        r_ev_addr <= r_word[CAND_W-1:0];
                    end else begin
                        r_ev_vld <= 1'b0;
                    end
                    if (take && reached) begin
                        // count met: rest of the word is dropped
                        r_phase               <= ph_next;
                        r_count               <= '0;
                        r_strobe              <= 1'b1;
                        r_res.coefficient     <= COEF_ZERO;
                        r_res.phase           <= ph_next;
                        r_res.placed_in_phase <= '0;
                        r_state               <= S_IDLE;
                    end else begin
                        if (take) begin
                            r_count <= cnt_inc;
                        end
                        if (r_ev_vld && !issue) begin
                            r_strobe              <= 1'b1;
                            r_res.coefficient     <= COEF_ZERO;
                            r_res.phase           <= r_phase;
                            r_res.placed_in_phase <= take ? cnt_inc : r_count;
                            r_state               <= S_IDLE;
                        end
                    end
                end
                S_READ: begin
                    r_strobe              <= 1'b1;
                    r_res.coefficient     <= r_rd_oob ? COEF_ZERO : i_rd_data;
                    r_res.phase           <= r_phase;
                    r_res.placed_in_phase <= r_count;
                    r_state               <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

@@ hdl/fixed_weight_ternary_sampler.sv @@
// ----------------------------------------------------------------------------
// fixed_weight_ternary_sampler
// Rejection sampler that fills a ternary polynomial with a fixed number of
// +1 and -1 coefficients from random words.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A random word's
// candidate slots go one after another (stopping once the phase count is met)
// through a read-modify-write of the coefficient memory, which has one write
// port and one read port, so the write of one slot overlaps the read of the
// next. A read is answered from S_READ after the registered memory read; an
// unknown request, a word once the fill is complete, or a word whose count
// is already met is answered from idle. After reset, and after every start
// request, the block clears the memory one entry a cycle and stays busy for
// the sweep; the start's result follows the sweep. Each request gives one
// result on o_res for a single cycle, marked by o_strobe; it cannot be held
// off, and the next request may be taken in that same cycle. Configuration
// writes are meant only while the block is idle.
module fixed_weight_ternary_sampler #(
    parameter int MAX_LENGTH     = 1024,
    parameter int SLOTS_PER_WORD = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  fwts_pkg::t_req_item               i_req,
    output logic                              o_strobe,
    output fwts_pkg::t_res_item               o_res,
    input  logic                              i_cfg_we,
    input  logic [fwts_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fwts_pkg::CFG_DAT_W-1:0]    i_cfg_data
);
    import fwts_pkg::*;

    t_cfg     r_cfg;
    t_mem_cmd mem_cmd;
    t_coef    rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poly_length  <= LEN_W'(1024);
            r_cfg.minus_weight <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POLY_LENGTH:  r_cfg.poly_length  <= i_cfg_data[LEN_W-1:0];
                CFG_MINUS_WEIGHT: r_cfg.minus_weight <= i_cfg_data[WT_W-1:0];
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    fwts_mem #(
        .DEPTH (MAX_LENGTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_cmd     (mem_cmd),
        .o_rd_data (rd_data)
    );

    fwts_seq #(
        .MAX_LENGTH     (MAX_LENGTH),
        .SLOTS_PER_WORD (SLOTS_PER_WORD)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_req     (i_req),
        .i_cfg     (r_cfg),
        .i_rd_data (rd_data),
        .o_busy    (busy),
        .o_mem     (mem_cmd),
        .o_strobe  (o_strobe),
        .o_res     (o_res)
    );

endmodule

@@ hdl/fwts_chk.sv @@
// ----------------------------------------------------------------------------
// fwts_chk
// Port-level checks of the sampler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module fwts_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input fwts_pkg::t_req_item i_req,
    input logic                o_strobe,
    input fwts_pkg::t_res_item o_res
);
    import fwts_pkg::*;

    // reset always starts a clearing sweep
    a_rst_sweep: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("no clearing sweep after reset");

    a_beat_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result beat while busy");

    a_done_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_res.phase == PH_DONE) |-> (o_res.placed_in_phase == '0))
        else $error("count not cleared when fill complete");

    a_coef_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_res.coefficient != 2'b10))
        else $error("coefficient out of ternary range");

    // a read answers after the registered memory read and the S_READ state, with no result in between
    a_read_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req.req_type == REQ_READ) |=> !o_strobe ##1 o_strobe)
        else $error("read result latency wrong");

endmodule

bind fixed_weight_ternary_sampler fwts_chk u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_req    (i_req),
    .o_strobe (o_strobe),
    .o_res    (o_res)
);
